// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define CT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// Consequent checked on the edge after the antecedent, outside reset.
`define CT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ct_pkg.sv =====
`default_nettype none

package ct_pkg;

  localparam int X_W        = 32;  // angle width
  localparam int MAG_W      = 62;  // term magnitude width
  localparam int SUM_W      = 40;  // series sum width
  localparam int CNT_W      = 11;  // term count width
  localparam int EPS_W      = 31;
  localparam int LIM_W      = 10;
  localparam int D_W        = 22;  // divisor (2n-1)(2n) for n up to 1024
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_EPS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 1'b1;

  localparam logic [EPS_W-1:0] EPS_RESET = 31'd268;
  localparam logic [LIM_W-1:0] LIM_RESET = 10'd1000;

  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

endpackage

`default_nettype wire

// ===== rtl/core/ct_angle_if.sv =====
`default_nettype none

interface ct_angle_if;
  import ct_pkg::*;

  logic                  valid;
  logic                  ready;
  logic signed [X_W-1:0] x_angle;

  modport source (output valid, output x_angle, input ready);
  modport sink (input valid, input x_angle, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ct_result_if.sv =====
`default_nettype none

interface ct_result_if;
  import ct_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] cos_approx;
  logic [CNT_W-1:0]        term_count;
  logic                    limit_hit;

  modport source (output valid, output cos_approx, output term_count, output limit_hit,
                  input ready);
  modport sink (input valid, input cos_approx, input term_count, input limit_hit,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cosine_taylor_series.sv =====
// Channel   Direction  Beat contents
// angle     in         x_angle (signed, FRAC_BITS fraction bits)
// result    out        cos_approx, term_count, limit_hit
// cfg       in         cfg_we, cfg_index, cfg_data (eps_threshold, term_limit)
//
// One shared adder does the squaring, the shift-add multiply, the restoring divide
// and the running sum. An angle is squared first; then each term is added to the sum
// and, unless the term limit is reached or the term falls below eps_threshold, the next
// term is formed by a multiply by x^2 and a divide; a finish step then posts the result.
// angle.ready is high only while the sequencer is idle; a result held in the output
// register by a stalled sink does not block the next angle, but the finish step waits.
// rst is synchronous and active high; it restores both registers to their defaults.
`default_nettype none
`include "assert_macros.svh"

module cosine_taylor_series #(
  parameter int FRAC_BITS = 28
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           cfg_we,
  input  wire [ct_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [ct_pkg::CFG_DATA_W-1:0]  cfg_data,
  ct_angle_if.sink                      angle,
  ct_result_if.source                   result
);
  import ct_pkg::*;

  localparam int X2W  = 63 - FRAC_BITS;          // width of x^2
  localparam int PW   = MAG_W + X2W;             // product width
  localparam int QW   = PW - FRAC_BITS;          // dividend width
  localparam int AW   = PW + 1;                  // shared adder width
  localparam int QXW  = (QW > MAG_W) ? QW : MAG_W;
  localparam int IT_W = $clog2(QW);

  typedef enum logic [2:0] {
    S_IDLE, S_SQUARE, S_ACCUM, S_MULT, S_DIV, S_FINISH
  } state_t;

  state_t                  state;
  logic [EPS_W-1:0]        eps;
  logic [LIM_W-1:0]        limit;
  logic [PW-1:0]           prod;
  logic [QW-1:0]           quo;
  logic [D_W-1:0]          rem;
  logic [D_W-1:0]          d;
  logic [X2W-1:0]          x2;
  logic [MAG_W-1:0]        mag;
  logic                    neg;
  logic signed [SUM_W-1:0] sum;
  logic [CNT_W-1:0]        n;
  logic                    hit;
  logic [IT_W-1:0]         cnt;

  logic [X_W-1:0]          ax_in;
  logic [AW-1:0]           alu_a;
  logic [AW-1:0]           alu_b;
  logic                    alu_sub;
  logic [AW-1:0]           alu_y;
  logic [D_W-1:0]          rp;
  logic                    ge;
  logic [D_W-1:0]          rem_next;
  logic [QW-1:0]           quo_next;
  logic [QXW-1:0]          quo_ext;
  logic [MAG_W-1:0]        mag_div;
  logic signed [SUM_W-1:0] sum_next;
  logic [CNT_W-1:0]        n_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps   <= EPS_RESET;
      limit <= LIM_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_EPS) begin
        eps <= cfg_data[EPS_W-1:0];
      end else if (cfg_index == REG_LIMIT) begin
        limit <= cfg_data[LIM_W-1:0];
      end
    end
  end

  assign ax_in = angle.x_angle[X_W-1] ? X_W'(~angle.x_angle + 1'b1)
                                      : X_W'(angle.x_angle);

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      S_SQUARE, S_MULT: begin
        alu_a = {1'b0, prod[PW-2:0], 1'b0};
        alu_b = quo[QW-1] ? AW'(mag) : '0;
      end
      S_DIV: begin
        alu_a   = AW'({rem, quo[QW-1]});
        alu_b   = AW'(d);
        alu_sub = 1'b1;
      end
      S_ACCUM: begin
        alu_a   = {{(AW-SUM_W){sum[SUM_W-1]}}, sum};
        alu_b   = AW'(mag);
        alu_sub = neg;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign alu_y = alu_a + (alu_sub ? ~alu_b : alu_b) + AW'(alu_sub);

  // Restoring divide step and the clamp on the final quotient. When the trial
  // subtraction fails the shifted remainder is below the divisor, so its top bit is clear.
  assign rp       = {rem[D_W-2:0], quo[QW-1]};
  assign ge       = ~alu_y[AW-1];
  assign rem_next = ge ? alu_y[D_W-1:0] : rp;
  assign quo_next = {quo[QW-2:0], ge};
  assign quo_ext  = QXW'(quo_next);
  assign mag_div  = (quo_ext > QXW'(MAG_MAX)) ? MAG_MAX : quo_ext[MAG_W-1:0];

  // The sum fits only if every bit above the 40-bit sign agrees with it.
  always_comb begin
    if (&alu_y[AW-1:SUM_W-1] || ~|alu_y[AW-1:SUM_W-1]) begin
      sum_next = alu_y[SUM_W-1:0];
    end else begin
      sum_next = alu_y[AW-1] ? SUM_MIN : SUM_MAX;
    end
  end

  assign n_next      = n + 1'b1;
  assign angle.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready && state != S_FINISH) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (angle.valid) begin
            mag   <= MAG_W'(ax_in);
            quo   <= {ax_in, {(QW-X_W){1'b0}}};
            prod  <= '0;
            cnt   <= '0;
            state <= S_SQUARE;
          end
        end
        S_SQUARE: begin
          prod <= alu_y[PW-1:0];
          quo  <= {quo[QW-2:0], 1'b0};
          cnt  <= cnt + 1'b1;
          if (cnt == IT_W'(X_W-1)) begin
            x2    <= alu_y[62:FRAC_BITS];
            mag   <= MAG_W'(1) << FRAC_BITS;
            neg   <= 1'b0;
            sum   <= '0;
            n     <= '0;
            d     <= '0;
            hit   <= 1'b0;
            state <= S_ACCUM;
          end
        end
        S_ACCUM: begin
          sum <= sum_next;
          n   <= n_next;
          if (n_next > CNT_W'(limit)) begin
            hit   <= 1'b1;
            state <= S_FINISH;
          end else if (mag < MAG_W'(eps)) begin
            state <= S_FINISH;
          end else begin
            // d steps from (2n-1)(2n) to (2n+1)(2n+2) by adding 8n+2.
            d     <= d + D_W'({n, 3'b010});
            neg   <= ~neg;
            prod  <= '0;
            quo   <= {x2, {(QW-X2W){1'b0}}};
            cnt   <= '0;
            state <= S_MULT;
          end
        end
        S_MULT: begin
          prod <= alu_y[PW-1:0];
          quo  <= {quo[QW-2:0], 1'b0};
          cnt  <= cnt + 1'b1;
          if (cnt == IT_W'(X2W-1)) begin
            quo   <= alu_y[PW-1:FRAC_BITS];
            rem   <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= rem_next;
          quo <= quo_next;
          cnt <= cnt + 1'b1;
          if (cnt == IT_W'(QW-1)) begin
            mag   <= mag_div;
            state <= S_ACCUM;
          end
        end
        S_FINISH: begin
          if (!result.valid || result.ready) begin
            result.valid      <= 1'b1;
            result.cos_approx <= sum;
            result.term_count <= n;
            result.limit_hit  <= hit;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `CT_ASSERT(a_rem_below_divisor, (state != S_DIV) || (rem < d), "remainder not below divisor")
  `CT_ASSERT(a_count_within_limit, (state != S_ACCUM) || (n <= CNT_W'(limit)), "count past limit")
  `CT_ASSERT(a_result_from_finish, !$rose(result.valid) || ($past(state) == S_FINISH), "no finish")
  `CT_ASSERT_NEXT(a_accept_starts_square, angle.valid && angle.ready, state == S_SQUARE, "no start")

endmodule

`default_nettype wire
